// ===== rtl/core/arj_method4_lz_decoder_unit_macros.svh =====
// Assertion macros for the ARJ method 4 decoder unit.
`ifndef ARJ_METHOD4_LZ_DECODER_UNIT_MACROS_SVH
`define ARJ_METHOD4_LZ_DECODER_UNIT_MACROS_SVH

// Implication checked on every clock, quiet while reset is asserted.
`define ARJ4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen.
`define ARJ4_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/arj4_pkg.sv =====
// ----------------------------------------------------------------------------
// arj4_pkg
// Shared types and constants of the ARJ method 4 decoder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package arj4_pkg;

  localparam int unsigned WinDepth   = 32768;
  localparam int unsigned WinAw      = $clog2(WinDepth);
  localparam int unsigned ResBytes   = 8;
  localparam int unsigned ResIdxW    = $clog2(ResBytes);
  localparam int unsigned ResCntW    = 4;
  localparam int unsigned LimitW     = 32;
  localparam int unsigned AccW       = 13;
  localparam int unsigned LenW       = 9;

  localparam logic [3:0] LenPrefixMax = 4'd7;
  localparam logic [3:0] PtrPrefixMin = 4'd9;
  localparam logic [3:0] PtrPrefixMax = 4'd13;
  localparam logic [3:0] LiteralBits  = 4'd8;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    PH_LEN_PREFIX,
    PH_LEN_RAW,
    PH_LITERAL,
    PH_PTR_PREFIX,
    PH_PTR_RAW
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FLUSH
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/arj_method4_lz_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// arj_method4_lz_decoder_unit
// Bit-serial ARJ method 4 ("fastest") decompressor with a 32K history window.
// ----------------------------------------------------------------------------
// Each compressed byte is one input transaction. Its eight bits are parsed
// one per clock unless a match copy or a held full result stalls parsing.
// A byte that completes no match passes through the bit steps, an
// end-of-byte check, a flush step (a result, if any, is loaded then) and the
// idle state that takes the next byte. A match copies each byte by a window
// read, then a write, through the 32K x 8 window memory; a full result
// shipped mid-copy comes before that write, and the copy is left from the
// read state. A full result that must leave while the output register is
// still held stalls parsing or copying until it frees. Decoded bytes are
// packed 8 to a result transaction; mid-step, a full result is sent only
// when a ninth byte needs room, and the last result of a step carries
// run_end, plus finished once the decoder has stopped. A result waiting on
// the output does not stall parsing until the next byte needs its slot.
// The window needs no clearing pass: a write pointer plus a wrapped flag
// tells which entries were ever written, and the rest read as zero.
// The output limit register may be written whenever the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module arj_method4_lz_decoder_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // compressed input
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [7:0]                  data_byte_i,
  input  wire                         final_byte_i,
  // configuration
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [arj4_pkg::LimitW-1:0] cfg_output_limit_i,
  // decoded output
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [7:0]                  out_byte_0_o,
  output logic [7:0]                  out_byte_1_o,
  output logic [7:0]                  out_byte_2_o,
  output logic [7:0]                  out_byte_3_o,
  output logic [7:0]                  out_byte_4_o,
  output logic [7:0]                  out_byte_5_o,
  output logic [7:0]                  out_byte_6_o,
  output logic [7:0]                  out_byte_7_o,
  output logic [arj4_pkg::ResCntW-1:0] valid_count_o,
  output logic                        run_end_o,
  output logic                        finished_o
);
  import arj4_pkg::*;

  // control
  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic                 stopped_q, stopped_d;
  logic [3:0]           pw_q, pw_d;          // prefix width
  logic [3:0]           raw_q, raw_d;        // raw bits left
  logic [AccW-1:0]      acc_q, acc_d;
  logic [LenW-1:0]      pend_q, pend_d;      // pending match length
  logic [3:0]           bitcnt_q, bitcnt_d;  // bits left in the current byte
  logic [7:0]           shreg_q, shreg_d;    // byte shifted out MSB first
  logic                 last_q, last_d;
  logic [LimitW-1:0]    limit_q, limit_d;
  logic [LimitW-1:0]    prod_q, prod_d;
  logic [WinAw-1:0]     wpos_q, wpos_d;
  logic                 wrapped_q, wrapped_d;
  logic [WinAw-1:0]     dist_q, dist_d;
  logic                 srcok_q, srcok_d;

  // result packing
  byte_t                buf_q [ResBytes];
  byte_t                buf_d [ResBytes];
  logic [ResCntW-1:0]   bcnt_q, bcnt_d;

  // output register
  logic                 ovld_q, ovld_d;
  byte_t                obyte_q [ResBytes];
  byte_t                obyte_d [ResBytes];
  logic [ResCntW-1:0]   ocnt_q, ocnt_d;
  logic                 orun_q, orun_d;
  logic                 ofin_q, ofin_d;

  // window memory
  byte_t                win_mem [WinDepth];
  byte_t                rdata_q;
  logic                 mem_we, mem_re;
  byte_t                mem_wdata;
  logic [WinAw-1:0]     mem_raddr;

  // helpers
  logic                 bit_in, at_start, limit_hit, out_free, buf_full;
  logic [AccW-1:0]      acc_sh;
  logic [WinAw-1:0]     src;

  assign bit_in    = shreg_q[7];
  assign acc_sh    = {acc_q[AccW-2:0], bit_in};
  assign at_start  = (phase_q == PH_LEN_PREFIX) && (pw_q == 4'd0);
  assign limit_hit = (prod_q >= limit_q);
  assign out_free  = !ovld_q || out_ready_i;
  assign buf_full  = (bcnt_q == ResCntW'(ResBytes));
  assign src       = wpos_q - dist_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    stopped_d = stopped_q;
    pw_d      = pw_q;
    raw_d     = raw_q;
    acc_d     = acc_q;
    pend_d    = pend_q;
    bitcnt_d  = bitcnt_q;
    shreg_d   = shreg_q;
    last_d    = last_q;
    limit_d   = limit_q;
    prod_d    = prod_q;
    wpos_d    = wpos_q;
    wrapped_d = wrapped_q;
    dist_d    = dist_q;
    srcok_d   = srcok_q;
    buf_d     = buf_q;
    bcnt_d    = bcnt_q;
    ovld_d    = ovld_q;
    obyte_d   = obyte_q;
    ocnt_d    = ocnt_q;
    orun_d    = orun_q;
    ofin_d    = ofin_q;
    mem_we    = 1'b0;
    mem_wdata = acc_sh[7:0];
    mem_re    = 1'b0;
    mem_raddr = src;

    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end
    if (cfg_valid_i) begin
      limit_d = cfg_output_limit_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !stopped_q) begin
          shreg_d  = data_byte_i;
          last_d   = final_byte_i;
          bitcnt_d = 4'd8;
          state_d  = ST_BITS;
        end
      end

      ST_BITS: begin
        if (bitcnt_q == 4'd0) begin
          if ((at_start && limit_hit) || last_q) begin
            stopped_d = 1'b1;
            phase_d   = PH_LEN_PREFIX;
            pw_d      = 4'd0;
            acc_d     = '0;
            raw_d     = 4'd0;
          end
          state_d = ST_FLUSH;
        end else if (at_start && limit_hit) begin
          stopped_d = 1'b1;
          acc_d     = '0;
          raw_d     = 4'd0;
          state_d   = ST_FLUSH;
        end else if (phase_q == PH_LITERAL && raw_q == 4'd1 && !limit_hit && buf_full) begin
          // literal needs a slot: ship the full result first
          if (out_free) begin
            ovld_d  = 1'b1;
            obyte_d = buf_q;
            ocnt_d  = bcnt_q;
            orun_d  = 1'b0;
            ofin_d  = 1'b0;
            bcnt_d  = '0;
            for (int k = 0; k < ResBytes; k++) buf_d[k] = '0;
          end
        end else begin
          shreg_d  = {shreg_q[6:0], 1'b0};
          bitcnt_d = bitcnt_q - 4'd1;
          case (phase_q)
            PH_LEN_PREFIX: begin
              acc_d = '0;
              if (bit_in) begin
                pw_d = pw_q + 4'd1;
                if (pw_q + 4'd1 >= LenPrefixMax) begin
                  phase_d = PH_LEN_RAW;
                  raw_d   = LenPrefixMax;
                end
              end else if (pw_q == 4'd0) begin
                phase_d = PH_LITERAL;
                raw_d   = LiteralBits;
              end else begin
                phase_d = PH_LEN_RAW;
                raw_d   = pw_q;
              end
            end
            PH_LEN_RAW: begin
              acc_d = acc_sh;
              raw_d = raw_q - 4'd1;
              if (raw_q == 4'd1) begin
                pend_d  = LenW'((LenW'(1) << pw_q) - LenW'(1) + LenW'(acc_sh) + LenW'(2));
                phase_d = PH_PTR_PREFIX;
                pw_d    = PtrPrefixMin;
                acc_d   = '0;
              end
            end
            PH_LITERAL: begin
              acc_d = acc_sh;
              raw_d = raw_q - 4'd1;
              if (raw_q == 4'd1) begin
                if (!limit_hit) begin
                  mem_we    = 1'b1;
                  mem_wdata = acc_sh[7:0];
                  buf_d[bcnt_q[ResIdxW-1:0]] = acc_sh[7:0];
                  bcnt_d    = bcnt_q + ResCntW'(1);
                  wpos_d    = wpos_q + WinAw'(1);
                  wrapped_d = wrapped_q || (wpos_q == '1);
                  prod_d    = prod_q + LimitW'(1);
                end
                phase_d = PH_LEN_PREFIX;
                pw_d    = 4'd0;
                acc_d   = '0;
                raw_d   = 4'd0;
              end
            end
            PH_PTR_PREFIX: begin
              acc_d = '0;
              if (bit_in) begin
                pw_d = pw_q + 4'd1;
                if (pw_q + 4'd1 >= PtrPrefixMax) begin
                  phase_d = PH_PTR_RAW;
                  raw_d   = PtrPrefixMax;
                end
              end else begin
                phase_d = PH_PTR_RAW;
                raw_d   = pw_q;
              end
            end
            PH_PTR_RAW: begin
              acc_d = acc_sh;
              raw_d = raw_q - 4'd1;
              if (raw_q == 4'd1) begin
                dist_d  = WinAw'((WinAw'(1) << pw_q) - WinAw'(512) + WinAw'(acc_sh)
                                 + WinAw'(1));
                phase_d = PH_LEN_PREFIX;
                pw_d    = 4'd0;
                acc_d   = '0;
                raw_d   = 4'd0;
                state_d = ST_COPY_RD;
              end
            end
            default: begin
              phase_d = PH_LEN_PREFIX;
              pw_d    = 4'd0;
              acc_d   = '0;
              raw_d   = 4'd0;
            end
          endcase
        end
      end

      ST_COPY_RD: begin
        if (pend_q == '0 || limit_hit) begin
          state_d = ST_BITS;
        end else begin
          mem_re  = 1'b1;
          srcok_d = wrapped_q || (src < wpos_q);
          state_d = ST_COPY_WR;
        end
      end

      ST_COPY_WR: begin
        if (buf_full) begin
          if (out_free) begin
            ovld_d  = 1'b1;
            obyte_d = buf_q;
            ocnt_d  = bcnt_q;
            orun_d  = 1'b0;
            ofin_d  = 1'b0;
            bcnt_d  = '0;
            for (int k = 0; k < ResBytes; k++) buf_d[k] = '0;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = srcok_q ? rdata_q : 8'h00;
          buf_d[bcnt_q[ResIdxW-1:0]] = mem_wdata;
          bcnt_d    = bcnt_q + ResCntW'(1);
          wpos_d    = wpos_q + WinAw'(1);
          wrapped_d = wrapped_q || (wpos_q == '1);
          prod_d    = prod_q + LimitW'(1);
          pend_d    = pend_q - LenW'(1);
          state_d   = ST_COPY_RD;
        end
      end

      ST_FLUSH: begin
        if (bcnt_q == '0 && !stopped_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          ovld_d  = 1'b1;
          obyte_d = buf_q;
          ocnt_d  = bcnt_q;
          orun_d  = 1'b1;
          ofin_d  = stopped_q;
          bcnt_d  = '0;
          for (int k = 0; k < ResBytes; k++) buf_d[k] = '0;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_LEN_PREFIX;
      stopped_q <= 1'b0;
      pw_q      <= '0;
      raw_q     <= '0;
      acc_q     <= '0;
      pend_q    <= '0;
      bitcnt_q  <= '0;
      last_q    <= 1'b0;
      limit_q   <= '0;
      prod_q    <= '0;
      wpos_q    <= '0;
      wrapped_q <= 1'b0;
      bcnt_q    <= '0;
      ovld_q    <= 1'b0;
      for (int k = 0; k < ResBytes; k++) buf_q[k] <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      stopped_q <= stopped_d;
      pw_q      <= pw_d;
      raw_q     <= raw_d;
      acc_q     <= acc_d;
      pend_q    <= pend_d;
      bitcnt_q  <= bitcnt_d;
      last_q    <= last_d;
      limit_q   <= limit_d;
      prod_q    <= prod_d;
      wpos_q    <= wpos_d;
      wrapped_q <= wrapped_d;
      bcnt_q    <= bcnt_d;
      ovld_q    <= ovld_d;
      buf_q     <= buf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    dist_q  <= dist_d;
    srcok_q <= srcok_d;
    obyte_q <= obyte_d;
    ocnt_q  <= ocnt_d;
    orun_q  <= orun_d;
    ofin_q  <= ofin_d;
  end

  // history window
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[wpos_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= win_mem[mem_raddr];
    end
  end

  assign out_valid_o   = ovld_q;
  assign out_byte_0_o  = obyte_q[0];
  assign out_byte_1_o  = obyte_q[1];
  assign out_byte_2_o  = obyte_q[2];
  assign out_byte_3_o  = obyte_q[3];
  assign out_byte_4_o  = obyte_q[4];
  assign out_byte_5_o  = obyte_q[5];
  assign out_byte_6_o  = obyte_q[6];
  assign out_byte_7_o  = obyte_q[7];
  assign valid_count_o = ocnt_q;
  assign run_end_o     = orun_q;
  assign finished_o    = ofin_q;

endmodule

`default_nettype wire

// ===== rtl/core/arj4_chk.sv =====
// ----------------------------------------------------------------------------
// arj4_chk
// Port-level checks of the ARJ method 4 decoder unit, bound to the decoder unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arj_method4_lz_decoder_unit_macros.svh"

module arj4_chk (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [7:0] out_byte_0_o,
  input wire [3:0] valid_count_o,
  input wire       run_end_o,
  input wire       finished_o
);

  `ARJ4_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_0_o) && $stable(valid_count_o), "result changed while stalled")
  `ARJ4_ASSERT(a_mid_full, out_valid_o && !run_end_o |-> valid_count_o == 4'd8, "non-final result not full")
  `ARJ4_ASSERT(a_fin_last, out_valid_o && finished_o |-> run_end_o, "finished on non-final result")
  `ARJ4_NEVER(a_cnt_range, out_valid_o && valid_count_o > 4'd8, "valid_count above eight")
  `ARJ4_NEVER(a_empty_open, out_valid_o && valid_count_o == 4'd0 && !finished_o, "empty result without stop")

endmodule

bind arj_method4_lz_decoder_unit arj4_chk u_arj4_chk (.*);

`default_nettype wire

// ===== bench/arj_method4_lz_checker.sv =====
// ----------------------------------------------------------------------------
// arj_method4_lz_checker
// Watches the decoder's channels, predicts its results and compares them.
// ----------------------------------------------------------------------------
// Every accepted compressed byte runs through a bit-serial decoder of our own
// with its own 32K window. The bytes it yields are packed into expected
// result transactions. Each output transaction is checked against the oldest
// one.
// ----------------------------------------------------------------------------
`default_nettype none

module arj_method4_lz_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [7:0]  data_byte_i,
  input  wire         final_byte_i,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_i,
  input  wire  [31:0] cfg_limit_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [7:0]  out_byte_i [8],
  input  wire  [3:0]  valid_count_i,
  input  wire         run_end_i,
  input  wire         finished_i,
  output int          mismatches_o,
  output int          awaited_o,
  output logic [31:0] produced_o,
  output logic        halted_o
);
  import arj4_pkg::*;

  typedef struct {
    byte_t      data [8];
    logic [3:0] cnt;
    logic       run_end;
    logic       finished;
  } decoded_t;

  decoded_t    awaited_q [$];
  byte_t       hist [WinDepth];
  logic [14:0] wr_pos;
  logic [31:0] produced;
  logic [31:0] limit;
  phase_e      phase;
  int unsigned width, acc, left, match_len;
  logic        halted;
  byte_t       step_q [$];

  assign awaited_o  = awaited_q.size();
  assign produced_o = produced;
  assign halted_o   = halted;

  function automatic void emit(byte_t b);
    hist[wr_pos] = b;
    wr_pos       = wr_pos + 15'd1;
    produced     = produced + 32'd1;
    step_q.push_back(b);
  endfunction

  function automatic void restart_token();
    phase = PH_LEN_PREFIX;
    width = 0;
    acc   = 0;
    left  = 0;
  endfunction

  function automatic void decode_bit(bit b);
    int unsigned span;
    case (phase)
      PH_LEN_PREFIX: begin
        if (b) begin
          width++;
          if (width >= 7) begin
            phase = PH_LEN_RAW;
            left  = 7;
          end
        end else if (width == 0) begin
          phase = PH_LITERAL;
          left  = 8;
        end else begin
          phase = PH_LEN_RAW;
          left  = width;
        end
        acc = 0;
      end
      PH_LEN_RAW: begin
        acc = ((acc << 1) | b) & 14'h3fff;
        left--;
        if (left == 0) begin
          match_len = (((1 << width) - 1) + acc + 2) & 9'h1ff;
          phase     = PH_PTR_PREFIX;
          width     = 9;
          acc       = 0;
        end
      end
      PH_LITERAL: begin
        acc = ((acc << 1) | b) & 14'h3fff;
        left--;
        if (left == 0) begin
          if (produced < limit) emit(acc[7:0]);
          restart_token();
        end
      end
      PH_PTR_PREFIX: begin
        if (b) begin
          width++;
          if (width >= 13) begin
            phase = PH_PTR_RAW;
            left  = 13;
          end
        end else begin
          phase = PH_PTR_RAW;
          left  = width;
        end
        acc = 0;
      end
      PH_PTR_RAW: begin
        acc = ((acc << 1) | b) & 14'h3fff;
        left--;
        if (left == 0) begin
          span = ((1 << width) - 512) + acc + 1;
          // overlapping copies read bytes written earlier in this same match
          for (int unsigned i = 0; i < match_len; i++) begin
            if (produced >= limit) break;
            emit(hist[15'(wr_pos - 15'(span))]);
          end
          restart_token();
        end
      end
      default: restart_token();
    endcase
  endfunction

  function automatic void decode_byte(byte_t data, logic last);
    int unsigned avail, nres;
    decoded_t    r;
    if (halted) return;
    step_q.delete();
    for (int i = 7; i >= 0; i--) begin
      if (phase == PH_LEN_PREFIX && width == 0 && produced >= limit) begin
        halted = 1'b1;
        break;
      end
      decode_bit(data[i]);
    end
    if (!halted && phase == PH_LEN_PREFIX && width == 0 && produced >= limit) halted = 1'b1;
    if (last) halted = 1'b1;
    if (halted) restart_token();
    avail = (step_q.size() > 32 * ResBytes) ? 32 * ResBytes : step_q.size();
    nres  = (avail + ResBytes - 1) / ResBytes;
    if (nres == 0) begin
      if (!halted) return;
      nres = 1;
    end
    for (int unsigned k = 0; k < nres; k++) begin
      r.cnt = 0;
      for (int unsigned j = 0; j < 8; j++) begin
        if (k * 8 + j < avail) begin
          r.data[j] = step_q[k * 8 + j];
          r.cnt++;
        end else begin
          r.data[j] = '0;
        end
      end
      r.run_end  = (k + 1 == nres);
      r.finished = (k + 1 == nres) && halted;
      awaited_q.push_back(r);
    end
  endfunction

  initial begin
    for (int i = 0; i < WinDepth; i++) hist[i] = '0;
    mismatches_o = 0;
    wr_pos       = '0;
    produced     = '0;
    limit        = '0;
    halted       = 1'b0;
    match_len    = 0;
    restart_token();
  end

  always @(posedge clk_i) begin
    decoded_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          $error("output transaction with nothing expected");
          mismatches_o++;
        end else begin
          e = awaited_q.pop_front();
          for (int j = 0; j < 8; j++) begin
            if (out_byte_i[j] !== e.data[j]) begin
              $error("out_byte_%0d: expected %0h, got %0h", j, e.data[j], out_byte_i[j]);
              mismatches_o++;
            end
          end
          if (valid_count_i !== e.cnt) begin
            $error("valid_count: expected %0d, got %0d", e.cnt, valid_count_i);
            mismatches_o++;
          end
          if (run_end_i !== e.run_end) begin
            $error("run_end: expected %0b, got %0b", e.run_end, run_end_i);
            mismatches_o++;
          end
          if (finished_i !== e.finished) begin
            $error("finished: expected %0b, got %0b", e.finished, finished_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i, final_byte_i);
      if (cfg_valid_i && cfg_ready_i) limit = cfg_limit_i;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_arj_method4_lz_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_arj_method4_lz_decoder_unit
// Stimulus and verdict for the ARJ method 4 decoder unit.
// ----------------------------------------------------------------------------
// Builds a compressed bit stream from literal and match tokens, with some
// raw noise bytes mixed in, and feeds it one byte per transaction. The output
// limit is changed between phases while the block is idle. The last phase
// sets a tight limit so the decoder stops; the checker does all comparing.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_arj_method4_lz_decoder_unit;

  localparam int unsigned MaxCycles = 3_000_000;
  // room for a 256-byte match copy, a window read and write per byte, plus bit parsing
  localparam int unsigned DrainCycles = 700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        final_byte = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_limit = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_bytes [8];
  logic [3:0]  valid_count;
  logic        run_end;
  logic        finished;

  int          mismatches, awaited;
  logic [31:0] produced;
  logic        halted;
  int unsigned cycles;
  int unsigned tx_idle_pct, rx_idle_pct;
  bit          stream_q [$];   // compressed bits, MSB first

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  arj_method4_lz_decoder_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .data_byte_i        (data_byte),
    .final_byte_i       (final_byte),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_output_limit_i (cfg_limit),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .out_byte_0_o       (out_bytes[0]),
    .out_byte_1_o       (out_bytes[1]),
    .out_byte_2_o       (out_bytes[2]),
    .out_byte_3_o       (out_bytes[3]),
    .out_byte_4_o       (out_bytes[4]),
    .out_byte_5_o       (out_bytes[5]),
    .out_byte_6_o       (out_bytes[6]),
    .out_byte_7_o       (out_bytes[7]),
    .valid_count_o      (valid_count),
    .run_end_o          (run_end),
    .finished_o         (finished)
  );

  arj_method4_lz_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .data_byte_i   (data_byte),
    .final_byte_i  (final_byte),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_limit_i   (cfg_limit),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_byte_i    (out_bytes),
    .valid_count_i (valid_count),
    .run_end_i     (run_end),
    .finished_i    (finished),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited),
    .produced_o    (produced),
    .halted_o      (halted)
  );

  // watchdog: a lost or missing result ends up here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("FAIL arj_method4_lz_decoder_unit");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // Append n bits of v, MSB first.
  task automatic push_bits(int unsigned v, int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) stream_q.push_back(v[i]);
  endtask

  // Match: w one-bits, a zero unless w is 7, w raw bits; distance alike, 9 to 13.
  task automatic push_match(int unsigned lw, int unsigned lraw, int unsigned dw,
                            int unsigned draw);
    push_bits('1, lw);
    if (lw < 7) push_bits(0, 1);
    push_bits(lraw, lw);
    push_bits('1, dw - 9);
    if (dw < 13) push_bits(0, 1);
    push_bits(draw, dw);
  endtask

  task automatic push_literal(byte unsigned b);
    push_bits(0, 1);
    push_bits(b, 8);
  endtask

  task automatic push_random_token();
    int unsigned sel, lw, dw;
    sel = $urandom_range(9);
    if (sel < 4) begin
      push_literal(8'($urandom));
    end else if (sel < 9) begin
      // mostly short matches and near distances, now and then the extremes
      lw = ($urandom_range(7) == 0) ? 7 : $urandom_range(1, 3);
      dw = ($urandom_range(3) == 0) ? $urandom_range(9, 13) : 9;
      push_match(lw, $urandom, dw, $urandom);
    end else begin
      push_bits($urandom, 8);   // noise byte, desyncs the parse
    end
  endtask

  // One input transaction: gap at random, then hold valid until accepted.
  task automatic send_byte(logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    while (stream_q.size() < 8) push_random_token();
    for (int i = 7; i >= 0; i--) data_byte[i] = stream_q.pop_front();
    final_byte = last;
    in_valid   = 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  // Only while idle: all results in, then room for a silent match copy.
  task automatic settle();
    while (awaited != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] v);
    @(negedge clk_i);
    cfg_limit = v;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(int unsigned n, int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned i = 0; i < n; i++) begin
      // hold off once mid-phase until every pending result is out
      if (i == n / 2) begin
        release_input();
        while (awaited != 0) @(posedge clk_i);
      end
      send_byte(1'b0);
    end
    release_input();
  endtask

  initial begin
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Register extremes: zero first, then all ones before any byte goes in.
    write_limit(32'd0);
    write_limit(32'hffff_ffff);

    // Directed: literal extremes, shortest match at distance 1 (overlap),
    // longest match at the farthest distance (reads unwritten window),
    // a mid-size match, and all-ones length and distance raw fields.
    push_literal(8'h00);
    push_literal(8'hff);
    push_match(1, 0, 9, 0);
    push_literal(8'ha5);
    push_match(7, 7'h7f, 13, 13'h1fff);
    push_match(3, 3'h5, 10, 10'h155);
    push_match(7, 0, 9, 9'h1ff);
    push_literal(8'h5a);
    push_match(2, 3, 12, 12'habc);
    while (stream_q.size() % 8 != 0) stream_q.push_back(1'b0);
    run_phase(stream_q.size() / 8, 0, 0);

    run_phase(70, 7, 64);
    settle();
    write_limit(32'h8000_0000);
    run_phase(70, 64, 7);
    settle();
    write_limit(32'hffff_fff0);
    run_phase(60, 0, 0);
    settle();

    // Tight limit: the decoder stops on it (possibly mid-match) or at the
    // final byte; bytes after the stop are ignored.
    write_limit(produced + $urandom_range(0, 40));
    tx_idle_pct = 7;
    rx_idle_pct = 30;
    for (int i = 0; i < 25 && !halted; i++) send_byte(1'b0);
    send_byte(1'b0);
    send_byte(1'b1);
    release_input();

    while (awaited != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS arj_method4_lz_decoder_unit");
    end else begin
      $display("FAIL arj_method4_lz_decoder_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/arj4_pkg.sv
rtl/core/arj_method4_lz_decoder_unit.sv
rtl/core/arj4_chk.sv
bench/arj_method4_lz_checker.sv
bench/tb_arj_method4_lz_decoder_unit.sv
